### sv/olws_pkg.sv
// Shared package of the ordered list with search unit.
// Holds request codes, status codes, field widths and the default depth.
// No dependencies.
`default_nettype none

package olws_pkg;

  localparam int OLWS_DEPTH = 16;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  // Request codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_POS = 2'd3;

endpackage

`default_nettype wire

### sv/olws_store.sv
// Ring storage of the ordered list: one write port, one registered read port.
// Logical indexes are mapped to physical slots relative to the head pointer.
// Depends on olws_pkg.
`default_nettype none

module olws_store #(
  parameter int DEPTH = olws_pkg::OLWS_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                        clk_i,
  input  wire  [AW-1:0]              head_i,
  input  wire                        wr_en_i,
  input  wire  [AW-1:0]              wr_idx_i,
  input  wire  [olws_pkg::DATA_W-1:0] wr_data_i,
  input  wire  [AW-1:0]              rd_idx_i,
  output logic [olws_pkg::DATA_W-1:0] rd_data_o
);
  import olws_pkg::*;

  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [AW-1:0]     wr_phys;
  logic [AW-1:0]     rd_phys;

  // head + idx, wrapped once at DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign wr_phys = wrap_add(head_i, wr_idx_i);
  assign rd_phys = wrap_add(head_i, rd_idx_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_phys] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_phys];
  end

endmodule

`default_nettype wire

### sv/ordered_list_with_search_unit.sv
// Ordered list (deque) with linear search; front is logical index 0.
// Push, pop, end insert, empty search, unused codes, failed requests: result next cycle.
// Insert at index p < c entries: shift moves one slot per cycle, then drain, then place.
// Search: one stored entry read and compared per cycle.
// busy is high while an insert or search walks the storage; no new item meanwhile.
// Reset (rst_ni low, async) empties the list; stored values stay undefined.
`default_nettype none

module ordered_list_with_search_unit #(
  parameter int DEPTH = olws_pkg::OLWS_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire  [olws_pkg::OP_W-1:0]    req_type_i,
  input  wire  signed [olws_pkg::DATA_W-1:0] value_i,
  input  wire  [CW-1:0]                position_i,
  output logic                         result_valid_o,
  output logic [olws_pkg::ST_W-1:0]    status_o,
  output logic                         found_o,
  output logic [AW-1:0]                found_index_o,
  output logic [CW-1:0]                entry_count_o
);
  import olws_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;  // move tail entries one slot back
  localparam logic [2:0] S_DRAIN = 3'd2;  // write the last moved entry
  localparam logic [2:0] S_PLACE = 3'd3;  // drop the new value into its slot
  localparam logic [2:0] S_SRCH  = 3'd4;  // read and compare one entry per cycle

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     head_q, head_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     s_q, s_d;            // walking index: shift source or search read
  logic [AW-1:0]     wr_idx_q, wr_idx_d;  // destination of the pending shift write
  logic              pend_q, pend_d;      // read data holds an entry still to be written
  logic              cmp_v_q, cmp_v_d;    // read data holds an entry to compare
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              res_vld_q, res_vld_d;
  logic [ST_W-1:0]   status_q, status_d;
  logic              found_q, found_d;
  logic [AW-1:0]     fidx_q, fidx_d;

  logic              mem_we;
  logic [AW-1:0]     mem_widx;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic [AW-1:0]     head_dec;
  logic [AW-1:0]     head_inc;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign is_full  = (count_q == FULL_CNT);
  assign is_empty = (count_q == '0);
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);

  olws_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .head_i    (head_q),
    .wr_en_i   (mem_we),
    .wr_idx_i  (mem_widx),
    .wr_data_i (mem_wdata),
    .rd_idx_i  (s_q),
    .rd_data_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    head_d    = head_q;
    val_d     = val_q;
    pos_d     = pos_q;
    s_d       = s_q;
    wr_idx_d  = wr_idx_q;
    pend_d    = pend_q;
    cmp_v_d   = cmp_v_q;
    cmp_idx_d = cmp_idx_q;
    res_vld_d = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    fidx_d    = fidx_q;
    mem_we    = 1'b0;
    mem_widx  = wr_idx_q;
    mem_wdata = mem_rdata;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // Every request that finishes here reports next cycle
          res_vld_d = 1'b1;
          status_d  = ST_OK;
          found_d   = 1'b0;
          fidx_d    = '0;
          val_d     = value_i;
          pos_d     = position_i[AW-1:0];
          pend_d    = 1'b0;
          cmp_v_d   = 1'b0;
          mem_wdata = value_i;
          case (req_type_i)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                // Logical DEPTH-1 relative to the old head is the new front slot
                mem_we   = 1'b1;
                mem_widx = LAST_IDX;
                head_d   = head_dec;
                count_d  = count_q + CW'(1);
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                mem_widx = count_q[AW-1:0];
                count_d  = count_q + CW'(1);
              end
            end
            OP_INSERT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else if (position_i > count_q) begin
                status_d = ST_BAD_POS;
              end else if (position_i == count_q) begin
                // Insert at the end: nothing to move
                mem_we   = 1'b1;
                mem_widx = count_q[AW-1:0];
                count_d  = count_q + CW'(1);
              end else begin
                res_vld_d = 1'b0;
                s_d       = count_q[AW-1:0] - AW'(1);
                state_d   = S_SHIFT;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                head_d  = head_inc;
                count_d = count_q - CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            OP_SEARCH: begin
              if (!is_empty) begin
                res_vld_d = 1'b0;
                s_d       = '0;
                state_d   = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Write the entry read last cycle one slot back, read the next one down
        mem_we   = pend_q;
        wr_idx_d = s_q + AW'(1);
        pend_d   = 1'b1;
        if (s_q == pos_q) begin
          state_d = S_DRAIN;
        end else begin
          s_d = s_q - AW'(1);
        end
      end

      S_DRAIN: begin
        mem_we  = 1'b1;
        pend_d  = 1'b0;
        state_d = S_PLACE;
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_widx  = pos_q;
        mem_wdata = val_q;
        count_d   = count_q + CW'(1);
        res_vld_d = 1'b1;
        status_d  = ST_OK;
        found_d   = 1'b0;
        fidx_d    = '0;
        state_d   = S_IDLE;
      end

      S_SRCH: begin
        if (cmp_v_q && (mem_rdata == val_q)) begin
          res_vld_d = 1'b1;
          found_d   = 1'b1;
          fidx_d    = cmp_idx_q;
          cmp_v_d   = 1'b0;
          state_d   = S_IDLE;
        end else if (cmp_v_q && ((CW'(cmp_idx_q) + CW'(1)) == count_q)) begin
          // Last entry compared without a match
          res_vld_d = 1'b1;
          cmp_v_d   = 1'b0;
          state_d   = S_IDLE;
        end else begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = s_q;
          s_d       = s_q + AW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      head_q    <= '0;
      pend_q    <= 1'b0;
      cmp_v_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      head_q    <= head_d;
      pend_q    <= pend_d;
      cmp_v_q   <= cmp_v_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    pos_q     <= pos_d;
    s_q       <= s_d;
    wr_idx_q  <= wr_idx_d;
    cmp_idx_q <= cmp_idx_d;
    status_q  <= status_d;
    found_q   <= found_d;
    fidx_q    <= fidx_d;
  end

  // count_q already holds the count after the reported request
  assign result_valid_o = res_vld_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign found_index_o  = fidx_q;
  assign entry_count_o  = count_q;

  // A push on a full list reports full and leaves the count alone
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_full &&
     (req_type_i == OP_PUSH_FRONT || req_type_i == OP_PUSH_BACK))
    |=> (res_vld_q && status_q == ST_FULL && $stable(count_q)))
    else $error("push on full list mishandled");

  // A pop on an empty list reports empty
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_empty &&
     (req_type_i == OP_POP_FRONT || req_type_i == OP_POP_BACK))
    |=> (res_vld_q && status_q == ST_EMPTY && count_q == '0))
    else $error("pop on empty list mishandled");

  // Leaving a multi-cycle walk always delivers its result
  a_walk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_vld_q)
    else $error("walk ended without a result");

  // A hit points inside the list and reports ok
  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && found_q) |-> (status_q == ST_OK && CW'(fidx_q) < count_q))
    else $error("search hit outside the list");

  // The count never exceeds the depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count above depth");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for ordered_list_with_search_unit (bounded deque with search).
// A scoreboard class mirrors the list contents and predicts every result.
// Depends on olws_pkg and the unit itself.

module tb;
  import olws_pkg::*;

  localparam int DEPTH = OLWS_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // Request codes the unit leaves unused; both must be a no-op with status ok
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CALM_FIRST   = 700;   // sender never idles in [CALM_FIRST, CALM_LAST)
  localparam int CALM_LAST    = 1100;
  localparam int TAIL_CYCLES  = 40;    // longer than the longest insert or search

  // Traffic mixes for the random part
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic            found;
    logic [AW-1:0]   found_index;
    logic [CW-1:0]   entry_count;
  } outcome_t;

  // Mirror of the list plus the queue of outcomes still owed by the unit
  class deque_scoreboard;
    logic [DATA_W-1:0] shadow_entries [DEPTH];
    int unsigned       shadow_count;
    outcome_t          owed_outcomes [$];
    int unsigned       errors;

    function new();
      shadow_count = 0;
      errors       = 0;
    endfunction

    // Open a slot at idx, shift the tail back and store v there
    function void place_entry(int unsigned idx, logic [DATA_W-1:0] v);
      int unsigned slot;
      for (slot = shadow_count; slot > idx; slot--)
        shadow_entries[slot] = shadow_entries[slot - 1];
      shadow_entries[idx] = v;
      shadow_count++;
    endfunction

    // Apply one accepted request to the mirror and queue its outcome
    function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] key,
                               logic [CW-1:0] pos);
      outcome_t    res;
      int unsigned slot;
      res = '0;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (shadow_count >= DEPTH) res.status = ST_FULL;
          else place_entry((op == OP_PUSH_FRONT) ? 0 : shadow_count, key);
        end
        OP_INSERT: begin
          // full is checked before the position
          if (shadow_count >= DEPTH) res.status = ST_FULL;
          else if (pos > shadow_count) res.status = ST_BAD_POS;
          else place_entry(pos, key);
        end
        OP_POP_FRONT: begin
          if (shadow_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            for (slot = 0; slot + 1 < shadow_count; slot++)
              shadow_entries[slot] = shadow_entries[slot + 1];
            shadow_count--;
          end
        end
        OP_POP_BACK: begin
          if (shadow_count == 0) res.status = ST_EMPTY;
          else shadow_count--;
        end
        OP_SEARCH: begin
          // lowest matching index wins
          for (slot = 0; slot < shadow_count; slot++) begin
            if (shadow_entries[slot] == key) begin
              res.found       = 1'b1;
              res.found_index = slot[AW-1:0];
              break;
            end
          end
        end
        default: ;
      endcase
      res.entry_count = shadow_count[CW-1:0];
      owed_outcomes.push_back(res);
    endfunction

    // Compare one strobed result with the oldest owed outcome
    function void check_result(outcome_t got);
      outcome_t want;
      if (owed_outcomes.size() == 0) begin
        $error("unexpected result: status %0d entry_count %0d", got.status, got.entry_count);
        errors++;
        return;
      end
      want = owed_outcomes.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.found_index !== want.found_index) begin
        $error("found_index: expected %0d, actual %0d", want.found_index, got.found_index);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start      = 1'b0;
  logic [OP_W-1:0]   req_type_i = OP_PUSH_FRONT;
  logic [DATA_W-1:0] value_i    = '0;
  logic [CW-1:0]     position_i = '0;
  logic              busy;
  logic              result_valid_o;
  logic [ST_W-1:0]   status_o;
  logic              found_o;
  logic [AW-1:0]     found_index_o;
  logic [CW-1:0]     entry_count_o;

  deque_scoreboard sb;
  bit              gaps_on = 1'b1;

  ordered_list_with_search_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_o        (found_o),
    .found_index_o  (found_index_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Sample the result strobe on the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result({status_o, found_o, found_index_o, entry_count_o});
  end

  // Idle at random, then hold start until the unit takes the item
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                           input logic [CW-1:0] pos);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 26) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start      <= 1'b1;
    req_type_i <= op;
    value_i    <= val;
    position_i <= pos;
    // accepted on the first edge that sees start high and busy low
    do @(posedge clk_i); while (busy);
    sb.note_request(op, val, pos);
  endtask

  // Drop start and hold off until every owed result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.owed_outcomes.size() != 0);
  endtask

  initial begin
    int                n;
    int                mix;
    int                roll;
    int                grow_pct;
    int                shrink_pct;
    int                pick;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] val;
    logic [CW-1:0]     pos;

    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-list errors, spare codes, single-entry pops,
    // insert at front, middle and end, bad positions, duplicate search
    send_item(OP_POP_FRONT, '0, '0);
    send_item(OP_POP_BACK,  '1, '1);
    send_item(OP_SEARCH,    '0, '0);
    send_item(OP_SPARE_LO,  32'd9, 5'd3);
    send_item(OP_SPARE_HI,  '1, '1);
    send_item(OP_INSERT,    32'd5, 5'd1);
    send_item(OP_INSERT,    VAL_MAX, 5'd0);
    send_item(OP_POP_BACK,  '0, '0);
    send_item(OP_PUSH_FRONT, VAL_MIN, '0);
    send_item(OP_POP_FRONT, '0, '0);
    send_item(OP_PUSH_BACK, 32'd0, '0);
    send_item(OP_PUSH_FRONT, '1, '0);
    send_item(OP_INSERT,    32'd7, 5'd2);
    send_item(OP_INSERT,    VAL_MAX, 5'd1);
    send_item(OP_INSERT,    VAL_MIN, 5'd0);
    send_item(OP_INSERT,    32'd3, 5'd16);
    send_item(OP_INSERT,    32'd3, '1);
    send_item(OP_PUSH_BACK, 32'd7, '0);
    send_item(OP_SEARCH,    32'd7, '0);
    send_item(OP_SEARCH,    VAL_MIN, '1);
    send_item(OP_SEARCH,    32'd12345, '0);
    send_item(OP_POP_FRONT, '0, '0);
    send_item(OP_POP_BACK,  '0, '0);
    drain_results();

    // Random part: switch between fill, drain and even mixes so the list
    // keeps hitting full and empty; keys often repeat stored values
    mix = MIX_EVEN;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = (n < CALM_FIRST) || (n >= CALM_LAST);
      if (n % 40 == 0) mix = $urandom_range(MIX_FILL, MIX_EVEN);
      case (mix)
        MIX_FILL:  begin grow_pct = 65; shrink_pct = 15; end
        MIX_DRAIN: begin grow_pct = 20; shrink_pct = 60; end
        default:   begin grow_pct = 40; shrink_pct = 35; end
      endcase

      roll = $urandom_range(0, 99);
      if (roll < grow_pct)
        op = (roll % 3 == 0) ? OP_PUSH_FRONT : (roll % 3 == 1) ? OP_PUSH_BACK : OP_INSERT;
      else if (roll < grow_pct + shrink_pct)
        op = roll[0] ? OP_POP_FRONT : OP_POP_BACK;
      else if (roll < 97)
        op = OP_SEARCH;
      else
        op = roll[0] ? OP_SPARE_LO : OP_SPARE_HI;

      pick = $urandom_range(0, 9);
      if (pick < 4 && sb.shadow_count > 0)
        val = sb.shadow_entries[$urandom_range(0, sb.shadow_count - 1)];
      else if (pick < 6)
        val = $urandom_range(0, 4) - 2;
      else if (pick == 6)
        val = roll[1] ? VAL_MAX : VAL_MIN;
      else
        val = $urandom;

      // mostly legal insert positions, some anywhere in the field
      if ($urandom_range(0, 99) < 85) pos = CW'($urandom_range(0, sb.shadow_count));
      else pos = CW'($urandom_range(0, 2**CW - 1));

      send_item(op, val, pos);
      if (n % 500 == 499) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_outcomes.size() == 0) begin
      $display("PASS ordered_list_with_search_unit");
    end else begin
      $display("FAIL ordered_list_with_search_unit");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAIL ordered_list_with_search_unit");
    $finish;
  end

endmodule
